### src/pcb_pkg.sv
// Shared types and constants for the per-peer circuit breaker.
// Used by pcb_entry_update and per_peer_circuit_breaker; depends on nothing.
package pcb_pkg;

  // Default size of the breaker table, and the slot space of an 8-bit peer index.
  localparam int unsigned PEER_SLOTS_DEF = 256;
  localparam int unsigned SLOT_SPACE     = 256;

  // Event codes carried in the func field.
  localparam logic [1:0] FN_REQUEST = 2'd0;
  localparam logic [1:0] FN_SUCCESS = 2'd1;
  localparam logic [1:0] FN_FAILURE = 2'd2;
  localparam logic [1:0] FN_QUERY   = 2'd3;

  // Breaker modes.
  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_HALF   = 2'd2;

  // Configuration register indexes and widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DUR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROBES = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  FAIL_THR_RST   = 8'd5;
  localparam logic [15:0] OPEN_DUR_RST   = 16'd30;
  localparam logic [7:0]  MAX_PROBES_RST = 8'd2;

  localparam logic [7:0] FAIL_CNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  peer_index;
    logic [31:0] now_secs;
  } in_t;

  typedef struct packed {
    logic       allowed;
    logic [1:0] circuit_mode;
  } out_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  fail_cnt;
    logic [7:0]  probe_cnt;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [7:0]  fail_thr;
    logic [15:0] open_dur;
    logic [7:0]  max_probes;
  } cfg_t;

endpackage

### src/pcb_entry_update.sv
// Next-state function of one breaker entry for one event.
// Depends on pcb_pkg for the entry, configuration and code definitions.
module pcb_entry_update
  import pcb_pkg::*;
(
  input  cfg_t        cfg,
  input  logic [1:0]  func,
  input  logic [31:0] now_secs,
  input  entry_t      cur,
  output entry_t      nxt,
  output logic        allowed
);

  logic [31:0] elapsed;
  entry_t      settled;
  logic [7:0]  fail_inc;

  assign elapsed = now_secs - cur.stamp;

  // An open entry whose wait is over turns half-open before the event is handled.
  always_comb begin
    settled = cur;
    if (cur.mode == MODE_OPEN && elapsed >= {16'd0, cfg.open_dur}) begin
      settled.mode      = MODE_HALF;
      settled.probe_cnt = 8'd0;
    end
  end

  assign fail_inc = (settled.fail_cnt == FAIL_CNT_MAX) ? settled.fail_cnt
                                                       : settled.fail_cnt + 8'd1;

  always_comb begin
    nxt     = settled;
    allowed = 1'b0;
    case (func)
      FN_SUCCESS: begin
        nxt           = cur;
        nxt.mode      = MODE_CLOSED;
        nxt.fail_cnt  = 8'd0;
        nxt.probe_cnt = 8'd0;
      end
      FN_REQUEST: begin
        if (settled.mode == MODE_CLOSED) begin
          allowed = 1'b1;
        end else if (settled.mode == MODE_HALF && settled.probe_cnt < cfg.max_probes) begin
          nxt.probe_cnt = settled.probe_cnt + 8'd1;
          allowed       = 1'b1;
        end
      end
      FN_FAILURE: begin
        if (settled.mode == MODE_HALF) begin
          nxt.mode  = MODE_OPEN;
          nxt.stamp = now_secs;
        end else begin
          nxt.fail_cnt = fail_inc;
          if (settled.mode == MODE_CLOSED && fail_inc >= cfg.fail_thr) begin
            nxt.mode  = MODE_OPEN;
            nxt.stamp = now_secs;
          end
        end
      end
      FN_QUERY: begin
        nxt = settled;
      end
      default: begin
        nxt = settled;
      end
    endcase
  end

endmodule

### src/per_peer_circuit_breaker.sv
// Top level of the per-peer circuit breaker: breaker table, pipeline and config registers.
// Depends on pcb_pkg and instantiates pcb_entry_update.
//
//   Channel   Ports                              Moves
//   --------  ---------------------------------  ---------------------------------------
//   input     start, busy, in_req                one event request: func, slot, time
//   result    out_valid, out_rsp                 allowed flag and mode, one cycle strobe
//   config    cfg_we, cfg_index, cfg_wdata       register write, no wait, no read-back
//
// A request is accepted at a clock edge with start high and busy low. Its result is
// strobed on out_valid through the read stage and the output register, and one request
// can be accepted every cycle while busy is low: the table is read at acceptance and
// written back in the next cycle, one read-modify-write of the table memory per request
// to a slot in the table. Reset is synchronous and active low; it clears the per-slot
// valid bits at once, so no clearing pass is needed, and busy is high during reset and
// drops once reset is released. The receiver cannot stall, so busy stays low from then on.
module per_peer_circuit_breaker
  import pcb_pkg::*;
#(
  parameter int unsigned PEER_SLOTS = PEER_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_req,
  output logic                  out_valid,
  output out_t                  out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Only the slots an 8-bit index can reach are stored.
  localparam int unsigned DEPTH = (PEER_SLOTS < SLOT_SPACE) ? PEER_SLOTS : SLOT_SPACE;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             busy_r;
  cfg_t             cfg_r;
  logic [DEPTH-1:0] valid_r;
  entry_t           mem [DEPTH];

  // Read stage.
  logic             s1_vld_r;
  in_t              s1_req_r;
  logic             s1_inrng_r;
  logic             s1_rdvld_r;
  entry_t           s1_rd_r;

  // Bypass of the entry written back in the previous cycle.
  logic             fwd_vld_r;
  logic [IDX_W-1:0] fwd_idx_r;
  entry_t           fwd_ent_r;

  logic             out_valid_r;
  out_t             out_rsp_r;
  out_t             out_rsp_nxt;

  logic             in_fire;
  logic             in_inrng;
  logic [IDX_W-1:0] in_idx;
  logic [IDX_W-1:0] s1_idx;
  logic             fwd_hit;
  entry_t           cur_ent;
  entry_t           upd_ent;
  logic             upd_allowed;
  logic             wr_en;

  assign in_fire  = start && !busy_r;
  assign in_inrng = 32'(in_req.peer_index) < PEER_SLOTS;
  assign in_idx   = in_req.peer_index[IDX_W-1:0];
  assign s1_idx   = s1_req_r.peer_index[IDX_W-1:0];

  // The table memory is read before the previous request's write lands, so an entry
  // written in the cycle of the read comes from the bypass register instead. Entries
  // whose valid bit is clear read as closed with zero counts.
  assign fwd_hit = fwd_vld_r && (fwd_idx_r == s1_idx);

  always_comb begin
    if (fwd_hit) begin
      cur_ent = fwd_ent_r;
    end else if (s1_rdvld_r) begin
      cur_ent = s1_rd_r;
    end else begin
      cur_ent           = s1_rd_r;
      cur_ent.mode      = MODE_CLOSED;
      cur_ent.fail_cnt  = 8'd0;
      cur_ent.probe_cnt = 8'd0;
    end
  end

  pcb_entry_update u_update (
    .cfg      (cfg_r),
    .func     (s1_req_r.func),
    .now_secs (s1_req_r.now_secs),
    .cur      (cur_ent),
    .nxt      (upd_ent),
    .allowed  (upd_allowed)
  );

  // Slots beyond the table are never touched and read as closed.
  assign wr_en = s1_vld_r && s1_inrng_r;

  always_comb begin
    if (s1_inrng_r) begin
      out_rsp_nxt.allowed      = upd_allowed;
      out_rsp_nxt.circuit_mode = upd_ent.mode;
    end else begin
      out_rsp_nxt.allowed      = (s1_req_r.func == FN_REQUEST);
      out_rsp_nxt.circuit_mode = MODE_CLOSED;
    end
  end

  // Table memory: one registered read and one write per cycle.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rd_r <= mem[in_idx];
    end
    if (wr_en) begin
      mem[s1_idx] <= upd_ent;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r           <= 1'b1;
      s1_vld_r         <= 1'b0;
      fwd_vld_r        <= 1'b0;
      out_valid_r      <= 1'b0;
      valid_r          <= '0;
      cfg_r.fail_thr   <= FAIL_THR_RST;
      cfg_r.open_dur   <= OPEN_DUR_RST;
      cfg_r.max_probes <= MAX_PROBES_RST;
    end else begin
      busy_r      <= 1'b0;
      s1_vld_r    <= in_fire;
      fwd_vld_r   <= wr_en;
      out_valid_r <= s1_vld_r;
      if (wr_en) begin
        valid_r[s1_idx] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FAIL_THR:   cfg_r.fail_thr   <= cfg_wdata[7:0];
          CFG_OPEN_DUR:   cfg_r.open_dur   <= cfg_wdata[15:0];
          CFG_MAX_PROBES: cfg_r.max_probes <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r   <= in_req;
      s1_inrng_r <= in_inrng;
      s1_rdvld_r <= valid_r[in_idx];
    end
    if (wr_en) begin
      fwd_idx_r <= s1_idx;
      fwd_ent_r <= upd_ent;
    end
    if (s1_vld_r) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Every result strobe traces back to an accepted request, through the read stage and the output register.
  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, 2))
    else $error("result strobe without an accepted request");

  // Only a request can ever be let through.
  a_allowed_only_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.allowed) |-> ($past(in_req.func, 2) == FN_REQUEST))
    else $error("allowed raised for an event other than a request");

  // An entry that ends the step open never lets a request through.
  a_open_denies: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.circuit_mode == MODE_OPEN) |-> !out_rsp.allowed)
    else $error("request allowed on an open circuit");

endmodule
